// ----- rtl/core/bda_pkg.sv -----
// bda_pkg: shared types and constants for the button debounce / auto-repeat block
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package bda_pkg;

    localparam int DEFAULT_BUTTON_COUNT = 4;

    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 8;
    localparam int DELAY_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int RCNT_W     = 3;

    localparam logic [INTERVAL_W-1:0] RESET_POLL_INTERVAL = 8'd25;
    localparam logic [DELAY_W-1:0]    RESET_REPEAT_DELAY  = 16'd250;
    localparam logic [RCNT_W-1:0]     RELEASE_RELOAD      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 1'b1;

    // event kinds
    localparam logic KIND_SINGLE = 1'b0;
    localparam logic KIND_ALL    = 1'b1;

    // handoff control from the poll stage to the event serializer
    typedef struct packed {
        logic valid;
        logic all_event;
    } poll_ctl_t;

endpackage

// ----- rtl/core/bda_poll.sv -----
// bda_poll: input register, debounce state and per-poll event decision
// depends on bda_pkg; feeds bda_emit
`timescale 1ns / 1ps

module bda_poll
    import bda_pkg::*;
#(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [TIME_W-1:0]       now_ms,
    input  logic [BUTTON_COUNT-1:0] raw_pressed,
    input  logic [INTERVAL_W-1:0]   poll_interval,
    input  logic [DELAY_W-1:0]      repeat_delay,
    input  logic                    emit_free,
    output poll_ctl_t               ctl,
    output logic [BUTTON_COUNT-1:0] fire_mask,
    output logic [BUTTON_COUNT-1:0] snapshot
);

    logic                    inq_valid_reg, inq_valid_next;
    logic [TIME_W-1:0]       inq_now_reg;
    logic [BUTTON_COUNT-1:0] inq_raw_reg;

    logic [TIME_W-1:0]       last_poll_reg, last_poll_next;
    logic [BUTTON_COUNT-1:0] held_reg, held_next;
    logic [RCNT_W-1:0]       rc_reg [BUTTON_COUNT];
    logic [RCNT_W-1:0]       rc_next [BUTTON_COUNT];
    logic [TIME_W-1:0]       nf_reg [BUTTON_COUNT];
    logic [TIME_W-1:0]       nf_next [BUTTON_COUNT];

    logic [BUTTON_COUNT-1:0] held_t;
    logic [RCNT_W-1:0]       rc_dec [BUTTON_COUNT];
    logic [RCNT_W-1:0]       rc_t [BUTTON_COUNT];
    logic [TIME_W-1:0]       nf_t [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] fire;
    logic [TIME_W-1:0]       limit;
    logic [TIME_W-1:0]       refire_ms;
    logic                    poll_ok;
    logic                    all_held;
    logic                    go;

    assign go       = inq_valid_reg && emit_free;
    assign in_ready = !inq_valid_reg || emit_free;

    always_comb
    begin
        inq_valid_next = inq_valid_reg;
        if (in_ready)
        begin
            inq_valid_next = in_valid;
        end
    end

    // sum wraps modulo 2^32 on purpose
    assign limit     = last_poll_reg + {{(TIME_W-INTERVAL_W){1'b0}}, poll_interval};
    assign refire_ms = inq_now_reg + {{(TIME_W-DELAY_W){1'b0}}, repeat_delay};
    assign poll_ok   = inq_now_reg >= limit;

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            rc_dec[i] = (rc_reg[i] == '0) ? '0 : rc_reg[i] - RCNT_W'(1);
            if (inq_raw_reg[i])
            begin
                held_t[i] = 1'b1;
                rc_t[i]   = RELEASE_RELOAD;
                nf_t[i]   = held_reg[i] ? nf_reg[i] : inq_now_reg;
            end
            else if (rc_dec[i] == RCNT_W'(1))
            begin
                // third idle poll in a row releases the button
                held_t[i] = 1'b0;
                rc_t[i]   = '0;
                nf_t[i]   = '0;
            end
            else
            begin
                held_t[i] = held_reg[i];
                rc_t[i]   = rc_dec[i];
                nf_t[i]   = nf_reg[i];
            end
        end
    end

    assign all_held = &held_t;

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            fire[i] = !all_held && held_t[i] && (nf_t[i] <= inq_now_reg);
        end
    end

    always_comb
    begin
        last_poll_next = last_poll_reg;
        held_next      = held_reg;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            rc_next[i] = rc_reg[i];
            nf_next[i] = nf_reg[i];
        end
        if (go && poll_ok)
        begin
            last_poll_next = inq_now_reg;
            held_next      = all_held ? '0 : held_t;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                rc_next[i] = all_held ? '0 : rc_t[i];
                nf_next[i] = fire[i] ? refire_ms : nf_t[i];
            end
        end
    end

    assign ctl.valid     = go && poll_ok && (all_held || (|fire));
    assign ctl.all_event = all_held;
    assign fire_mask     = fire;
    assign snapshot      = inq_raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
            last_poll_reg <= '0;
            held_reg      <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                rc_reg[i] <= '0;
                nf_reg[i] <= '0;
            end
        end
        else
        begin
            inq_valid_reg <= inq_valid_next;
            last_poll_reg <= last_poll_next;
            held_reg      <= held_next;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                rc_reg[i] <= rc_next[i];
                nf_reg[i] <= nf_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inq_now_reg <= now_ms;
            inq_raw_reg <= raw_pressed;
        end
    end

`ifndef SYNTH
    // the all-buttons case always clears every held flag
    assert property (@(posedge clk) disable iff (!rst_n) !(&held_reg))
        else $error("all buttons left held after a poll");

    generate
        for (genvar g = 0; g < BUTTON_COUNT; g++)
        begin : g_chk
            assert property (@(posedge clk) disable iff (!rst_n)
                !held_reg[g] |-> (rc_reg[g] == '0))
                else $error("released button keeps a release count");
            assert property (@(posedge clk) disable iff (!rst_n)
                (rc_reg[g] != RCNT_W'(1)) && (rc_reg[g] <= RELEASE_RELOAD))
                else $error("release count out of range");
        end
    endgenerate
`endif

endmodule

// ----- rtl/core/bda_emit.sv -----
// bda_emit: result register that serializes one poll's events, lowest button first
// depends on bda_pkg; driven by bda_poll
`timescale 1ns / 1ps

module bda_emit
    import bda_pkg::*;
#(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT,
    parameter int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  poll_ctl_t               ctl,
    input  logic [BUTTON_COUNT-1:0] fire_mask,
    input  logic [BUTTON_COUNT-1:0] snapshot,
    output logic                    emit_free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    event_kind,
    output logic [IDX_W-1:0]        button_index,
    output logic [BUTTON_COUNT-1:0] pressed_snapshot,
    output logic                    last_event
);

    logic                    valid_reg, valid_next;
    logic                    kind_reg;
    logic [BUTTON_COUNT-1:0] mask_reg;
    logic [BUTTON_COUNT-1:0] snap_reg;
    logic [BUTTON_COUNT-1:0] mask_rest;
    logic                    is_last;
    logic                    load;

    // mask with its lowest set bit removed
    assign mask_rest = mask_reg & (mask_reg - BUTTON_COUNT'(1));
    assign is_last   = (kind_reg == KIND_ALL) || (mask_rest == '0);
    assign emit_free = !valid_reg || (out_ready && is_last);
    assign load      = emit_free && ctl.valid;

    always_comb
    begin
        button_index = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                button_index = IDX_W'(i);
            end
        end
    end

    assign out_valid        = valid_reg;
    assign event_kind       = kind_reg;
    assign pressed_snapshot = snap_reg;
    assign last_event       = is_last;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit_free)
        begin
            valid_next = ctl.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= ctl.all_event ? KIND_ALL : KIND_SINGLE;
            mask_reg <= ctl.all_event ? '0 : fire_mask;
            snap_reg <= snapshot;
        end
        else if (valid_reg && out_ready)
        begin
            mask_reg <= mask_rest;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_ALL) |-> last_event)
        else $error("all-buttons event not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_SINGLE) |-> (mask_reg != '0))
        else $error("single event with no pending button");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_event) |=> (out_valid && $stable(snap_reg)))
        else $error("poll events cut short");
`endif

endmodule

// ----- rtl/core/button_debounce_autorepeat.sv -----
// button_debounce_autorepeat: top level, configuration registers and stage wiring
// depends on bda_pkg, bda_poll, bda_emit
//
// channel   direction  handshake              payload
// in        in         in_valid / in_ready    now_ms, raw_pressed
// out       out        out_valid / out_ready  event_kind, button_index, pressed_snapshot,
//                                              last_event
// cfg       in         cfg_write              cfg_index, cfg_data
//
// a poll is registered, then decided combinationally: debounce update, repeat check and
// the event set are written together, the events going to the result register
// the result register hands out one event per cycle while out_ready is high, so a poll
// firing n buttons holds it until all n are taken; polls with one event stream at one
// per cycle too; a rejected poll, or one with no event, produces no transfer
// all control state and debounce state clear on reset; no clearing pass
// out_ready low holds the result register and, through it, the input register
`timescale 1ns / 1ps

module button_debounce_autorepeat
    import bda_pkg::*;
#(
    parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT,
    parameter int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [TIME_W-1:0]       now_ms,
    input  logic [BUTTON_COUNT-1:0] raw_pressed,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    event_kind,
    output logic [IDX_W-1:0]        button_index,
    output logic [BUTTON_COUNT-1:0] pressed_snapshot,
    output logic                    last_event
);

    logic [INTERVAL_W-1:0]   poll_interval_reg, poll_interval_next;
    logic [DELAY_W-1:0]      repeat_delay_reg, repeat_delay_next;
    poll_ctl_t               ctl;
    logic [BUTTON_COUNT-1:0] fire_mask;
    logic [BUTTON_COUNT-1:0] snapshot;
    logic                    emit_free;

    always_comb
    begin
        poll_interval_next = poll_interval_reg;
        repeat_delay_next  = repeat_delay_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_POLL_INTERVAL: poll_interval_next = cfg_data[INTERVAL_W-1:0];
                REG_REPEAT_DELAY:  repeat_delay_next  = cfg_data[DELAY_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= RESET_POLL_INTERVAL;
            repeat_delay_reg  <= RESET_REPEAT_DELAY;
        end
        else
        begin
            poll_interval_reg <= poll_interval_next;
            repeat_delay_reg  <= repeat_delay_next;
        end
    end

    bda_poll #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_poll (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_ms        (now_ms),
        .raw_pressed   (raw_pressed),
        .poll_interval (poll_interval_reg),
        .repeat_delay  (repeat_delay_reg),
        .emit_free     (emit_free),
        .ctl           (ctl),
        .fire_mask     (fire_mask),
        .snapshot      (snapshot)
    );

    bda_emit #(
        .BUTTON_COUNT (BUTTON_COUNT),
        .IDX_W        (IDX_W)
    ) u_emit (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .fire_mask        (fire_mask),
        .snapshot         (snapshot),
        .emit_free        (emit_free),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_kind       (event_kind),
        .button_index     (button_index),
        .pressed_snapshot (pressed_snapshot),
        .last_event       (last_event)
    );

endmodule
